/* src/hok3_pkg.sv */
package hok3_pkg;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_REQUEST = 1'b1
  } mode_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  localparam logic [1:0] SRC_INVALID = 2'd3;

  localparam logic REG_BLOCK_BYTES = 1'b0;
  localparam logic REG_TAIL_BYTES  = 1'b1;

  // Low byte of the field polynomial 0x14D
  localparam logic [7:0]  GF_POLY_LOW  = 8'h4d;
  localparam logic [31:0] MIX_MUL_A    = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL_B    = 32'h846ca68b;
  localparam logic [15:0] BUCKET_SPLIT = 16'd65280;
  localparam logic [31:0] ID_MID_LIMIT = 32'd258;
  localparam logic [31:0] ID_UNIT_LIMIT = 32'd3;

  localparam int QUEUE_DEPTH  = 8;
  localparam int QPTR_W       = 3;
  localparam int QCNT_W       = 4;
  localparam int OCC_W        = QCNT_W + 1;
  localparam int FRONT_STAGES = 4;
  localparam int FLIGHT_W     = 3;
  // Edges from accept to the edge that takes the result
  localparam int LATENCY      = 7;

  typedef struct packed {
    mode_e       mode;
    logic        err;
    logic [1:0]  src;
    logic [11:0] idx;
    logic [7:0]  load_byte;
    logic [12:0] plen;
    logic [7:0]  alpha;
    logic [7:0]  beta;
    logic [7:0]  gamma;
    logic        tail_ok;
  } item_t;

  function automatic logic [7:0] gf_mul(logic [7:0] x, logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] xs;
    acc = 8'h00;
    xs  = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) acc = acc ^ xs;
      xs = xs[7] ? ({xs[6:0], 1'b0} ^ GF_POLY_LOW) : {xs[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

/* src/hok3_front.sv */
module hok3_front import hok3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  mode_e               mode_i,
  input  logic [1:0]          src_i,
  input  logic [31:0]         id_i,
  input  logic [11:0]         idx_i,
  input  logic [7:0]          load_byte_i,
  input  logic [12:0]         blen_i,
  input  logic [12:0]         tlen_i,
  output logic                push_o,
  output item_t               item_o,
  output logic [FLIGHT_W-1:0] inflight_o
);

  typedef struct packed {
    mode_e       mode;
    logic [1:0]  src;
    logic [11:0] idx;
    logic [7:0]  load_byte;
    logic        id_unit;
    logic        id_mid;
    logic        id_is2;
    logic [7:0]  id_low;
  } stage_t;

  logic   [FRONT_STAGES-1:0] v_q;
  stage_t                    st_q [FRONT_STAGES];
  stage_t                    st_d;

  logic [31:0] m1_q, m1_d, m2_q, m2_d;
  logic [15:0] b_q, b_d;
  logic [7:0]  a_q, a_d, r_q, r_d, bl_q;
  logic        hi_q, hi_d;

  logic [31:0] mix0, mix1, mix2;
  logic [47:0] scaled;
  logic [16:0] quot_sum;
  logic [15:0] a_times;
  logic [15:0] rem16;

  // Classify the id and start the avalanche mix
  always_comb begin
    st_d.mode      = mode_i;
    st_d.src       = src_i;
    st_d.idx       = idx_i;
    st_d.load_byte = load_byte_i;
    st_d.id_unit   = id_i < ID_UNIT_LIMIT;
    st_d.id_mid    = id_i < ID_MID_LIMIT;
    st_d.id_is2    = id_i == 32'd2;
    st_d.id_low    = id_i[7:0];
    mix0           = id_i ^ (id_i >> 16);
    m1_d           = mix0 * MIX_MUL_A;
    mix1           = m1_q ^ (m1_q >> 15);
    m2_d           = mix1 * MIX_MUL_B;
    mix2           = m2_q ^ (m2_q >> 16);
    // bucket = (h * 65535) >> 32
    scaled         = {mix2, 16'h0000} - {16'h0000, mix2};
    b_d            = scaled[47:32];
    // b / 255 and b % 255 by reciprocal, exact below 65280 (BUCKET_SPLIT)
    quot_sum       = {1'b0, b_q} + {9'h000, b_q[15:8]} + 17'd1;
    a_d            = quot_sum[15:8];
    a_times        = {quot_sum[15:8], 8'h00} - {8'h00, quot_sum[15:8]};
    rem16          = b_q - a_times;
    r_d            = rem16[7:0];
    hi_d           = b_q >= BUCKET_SPLIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[FRONT_STAGES-2:0], accept_i};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= st_d;
    for (int s = 1; s < FRONT_STAGES; s++) st_q[s] <= st_q[s-1];
    m1_q <= m1_d;
    m2_q <= m2_d;
    b_q  <= b_d;
    a_q  <= a_d;
    r_q  <= r_d;
    hi_q <= hi_d;
    bl_q <= b_q[7:0];
  end

  stage_t     last;
  logic [7:0] t_val, t_sq, a_sq;

  // Pick coefficients and length, flag errors
  always_comb begin
    last  = st_q[FRONT_STAGES-1];
    t_val = last.id_low - 8'd2;
    t_sq  = gf_mul(t_val, t_val);
    a_sq  = gf_mul(a_q, a_q);

    item_o.mode      = last.mode;
    item_o.src       = last.src;
    item_o.idx       = last.idx;
    item_o.load_byte = last.load_byte;
    item_o.tail_ok   = {1'b0, last.idx} < tlen_i;
    item_o.alpha     = 8'h00;
    item_o.beta      = 8'h00;
    item_o.gamma     = 8'h00;
    item_o.plen      = 13'd0;
    item_o.err       = STATUS_OK;

    if (last.mode == MODE_LOAD) begin
      if (last.src == SRC_INVALID || {1'b0, last.idx} >= blen_i) item_o.err = STATUS_ERROR;
    end else begin
      item_o.plen = last.id_is2 ? tlen_i : blen_i;
      if ({1'b0, last.idx} >= item_o.plen) item_o.err = STATUS_ERROR;
      if (last.id_unit) begin
        item_o.alpha = {7'h00, last.id_low[1:0] == 2'd0};
        item_o.beta  = {7'h00, last.id_low[1:0] == 2'd1};
        item_o.gamma = {7'h00, last.id_low[1:0] == 2'd2};
      end else if (last.id_mid) begin
        item_o.alpha = 8'h01;
        item_o.beta  = t_val;
        item_o.gamma = t_sq;
      end else if (hi_q) begin
        item_o.alpha = 8'h00;
        item_o.beta  = 8'h01;
        item_o.gamma = bl_q + 8'd1;
      end else begin
        item_o.alpha = 8'h01;
        item_o.beta  = a_q;
        item_o.gamma = a_sq ^ (r_q + 8'd1);
      end
    end
  end

  assign push_o     = v_q[FRONT_STAGES-1];
  assign inflight_o = FLIGHT_W'(v_q[0]) + FLIGHT_W'(v_q[1]) + FLIGHT_W'(v_q[2])
                    + FLIGHT_W'(v_q[3]);

endmodule

/* src/hok3_queue.sv */
module hok3_queue import hok3_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  item_t             item_i,
  input  logic              pop_i,
  output item_t             item_o,
  output logic              empty_o,
  output logic [QCNT_W-1:0] count_o
);

  item_t             entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_pop;

  always_comb begin
    do_pop   = pop_i && (count_q != '0);
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entries_q[wr_ptr_q] <= item_i;
  end

  assign item_o  = entries_q[rd_ptr_q];
  assign empty_o = count_q == '0;
  assign count_o = count_q;

endmodule

/* src/hok3_back.sv */
module hok3_back import hok3_pkg::*; #(
  parameter int BLOCK_MAX = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        valid_o,
  output logic [7:0]  packet_byte_o,
  output logic [12:0] packet_length_o,
  output logic [7:0]  coef_alpha_o,
  output logic [7:0]  coef_beta_o,
  output logic [7:0]  coef_gamma_o,
  output logic        status_o
);

  localparam int AW = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;

  logic [AW-1:0] addr;
  logic [7:0]    rd_q [3];
  logic          exec_valid_q;
  item_t         exec_q;

  assign addr = AW'(item_i.idx);

  for (genvar k = 0; k < 3; k++) begin : g_block
    logic [7:0] mem [BLOCK_MAX];
    logic       wr_en;
    assign wr_en = valid_i && item_i.mode == MODE_LOAD && !item_i.err
                && item_i.src == 2'(k);
    always_ff @(posedge clk_i) begin
      if (wr_en) mem[addr] <= item_i.load_byte;
      rd_q[k] <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_valid_q <= 1'b0;
      valid_o      <= 1'b0;
    end else begin
      exec_valid_q <= valid_i;
      valid_o      <= exec_valid_q;
    end
  end

  logic [7:0] byte_d;
  logic [7:0] s2;

  // Combine the three products; drop the tail of block 2
  always_comb begin
    s2     = exec_q.tail_ok ? rd_q[2] : 8'h00;
    byte_d = 8'h00;
    if (exec_q.mode == MODE_REQUEST && exec_q.err == STATUS_OK) begin
      byte_d = gf_mul(exec_q.alpha, rd_q[0]) ^ gf_mul(exec_q.beta, rd_q[1])
             ^ gf_mul(exec_q.gamma, s2);
    end
  end

  always_ff @(posedge clk_i) begin
    exec_q          <= item_i;
    packet_byte_o   <= byte_d;
    packet_length_o <= exec_q.plen;
    coef_alpha_o    <= exec_q.alpha;
    coef_beta_o     <= exec_q.beta;
    coef_gamma_o    <= exec_q.gamma;
    status_o        <= exec_q.err;
  end

endmodule

/* src/hyperoval_k3_packet_generator.sv */
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+-------------------------------------
// item in   | input     | start & !busy at clock edge  | mode, source_index, packet_id,
//           |           |                              | byte_index, load_byte
// result    | output    | valid_o high for one cycle   | packet_byte, packet_length, coefs,
//           |           |                              | status
// config    | input     | cfg_we_i at clock edge       | cfg_index_i, cfg_wdata_i
//
// One item enters per cycle while busy is low, and every accepted item gives one
// result. Its path runs through four stages of the front (two 32x32 mix multiplies,
// the bucket scale, the divide by 255), then the queue write, and in the back the
// registered source store read and then the registered field products.
// busy rises only when the front pipeline and the queue together could
// overfill the eight-entry queue; the back drains one item every cycle, so in
// use it stays low. The receiver cannot stall.
// Reset sets both length registers to one; the source store holds no reset
// value and needs no clearing pass.
module hyperoval_k3_packet_generator import hok3_pkg::*; #(
  parameter int BLOCK_MAX = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [1:0]  source_index_i,
  input  logic [31:0] packet_id_i,
  input  logic [11:0] byte_index_i,
  input  logic [7:0]  load_byte_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_wdata_i,
  output logic        valid_o,
  output logic [7:0]  packet_byte_o,
  output logic [12:0] packet_length_o,
  output logic [7:0]  coef_alpha_o,
  output logic [7:0]  coef_beta_o,
  output logic [7:0]  coef_gamma_o,
  output logic        status_o
);

  logic [12:0] block_bytes_q, tail_bytes_q;
  logic [12:0] blen, tlen;

  // Hold the length registers; the user sends writes only while idle, unchecked here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= 13'd1;
      tail_bytes_q  <= 13'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BLOCK_BYTES: block_bytes_q <= cfg_wdata_i;
        REG_TAIL_BYTES:  tail_bytes_q  <= cfg_wdata_i;
        default:         block_bytes_q <= block_bytes_q;
      endcase
    end
  end

  // Clamp block length to 1..BLOCK_MAX and tail length to 1..block length
  always_comb begin
    if (block_bytes_q == 13'd0) begin
      blen = 13'd1;
    end else if (32'(block_bytes_q) > 32'(BLOCK_MAX)) begin
      blen = 13'(BLOCK_MAX);
    end else begin
      blen = block_bytes_q;
    end
    if (tail_bytes_q == 13'd0) begin
      tlen = 13'd1;
    end else if (tail_bytes_q > blen) begin
      tlen = blen;
    end else begin
      tlen = tail_bytes_q;
    end
  end

  logic                accept;
  logic                push;
  item_t               push_item;
  item_t               head_item;
  logic                q_empty;
  logic [QCNT_W-1:0]   q_count;
  logic [FLIGHT_W-1:0] inflight;
  logic [OCC_W-1:0]    occupancy;

  // Refuse a new item when the queue could not take everything in flight
  assign occupancy = OCC_W'(q_count) + OCC_W'(inflight);
  assign busy      = occupancy >= OCC_W'(QUEUE_DEPTH);
  assign accept    = start && !busy;

  hok3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .mode_i      (mode_e'(mode_i)),
    .src_i       (source_index_i),
    .id_i        (packet_id_i),
    .idx_i       (byte_index_i),
    .load_byte_i (load_byte_i),
    .blen_i      (blen),
    .tlen_i      (tlen),
    .push_o      (push),
    .item_o      (push_item),
    .inflight_o  (inflight)
  );

  hok3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (!q_empty),
    .item_o  (head_item),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  // Advance the head item every cycle the queue holds one
  hok3_back #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (!q_empty),
    .item_i          (head_item),
    .valid_o         (valid_o),
    .packet_byte_o   (packet_byte_o),
    .packet_length_o (packet_length_o),
    .coef_alpha_o    (coef_alpha_o),
    .coef_beta_o     (coef_beta_o),
    .coef_gamma_o    (coef_gamma_o),
    .status_o        (status_o)
  );

endmodule

/* src/hok3_checker.sv */
module hok3_checker import hok3_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        mode_i,
  input logic [31:0] packet_id_i,
  input logic [11:0] byte_index_i,
  input logic        valid_o,
  input logic [7:0]  packet_byte_o,
  input logic [12:0] packet_length_o,
  input logic [7:0]  coef_alpha_o,
  input logic [7:0]  coef_beta_o,
  input logic [7:0]  coef_gamma_o,
  input logic        status_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY valid_o)
    else $error("accepted item gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted item");

  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(mode_i, LATENCY) == MODE_LOAD |->
      packet_byte_o == 8'h00 && packet_length_o == 13'd0 && coef_alpha_o == 8'h00
      && coef_beta_o == 8'h00 && coef_gamma_o == 8'h00)
    else $error("load result carries data");

  a_range_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(mode_i, LATENCY) == MODE_REQUEST |->
      (status_o == STATUS_ERROR) == ({1'b0, $past(byte_index_i, LATENCY)} >= packet_length_o)
      && (status_o == STATUS_OK || packet_byte_o == 8'h00))
    else $error("request status disagrees with packet length");

  a_unit_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(mode_i, LATENCY) == MODE_REQUEST
      && $past(packet_id_i, LATENCY) < ID_UNIT_LIMIT |->
      (coef_alpha_o | coef_beta_o | coef_gamma_o) == 8'h01
      && $onehot({coef_alpha_o[0], coef_beta_o[0], coef_gamma_o[0]}))
    else $error("low id did not give a unit vector");

endmodule

bind hyperoval_k3_packet_generator hok3_checker u_hok3_checker (.*);
